FILE: sv/pft_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pft_pkg;

  localparam int XY_W = 33;
  localparam int Z_W  = 34;
  localparam int MAX_STAGES = 24;

  localparam logic signed [XY_W-1:0] CORDIC_K = 33'sd652032874;

  localparam logic FUNC_TO_ABS = 1'b0;
  localparam logic FUNC_TO_REL = 1'b1;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_90,
    QUAD_180,
    QUAD_270
  } quad_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] stage_angle(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10680862;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: sv/planar_frame_transform.sv
// Throughput: one word per cycle while out_stall is low; each stage holds its word while the next
// is full, and bubbles collapse even while the output is stalled.
// The pipeline is a front stage, a chain of CORDIC_STAGES CORDIC cells and six rotate stages.
// Reset (synchronous, rst_n low) clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none
module planar_frame_transform #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_WIDTH   = 32,
  parameter int ANGLE_WIDTH   = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_func,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_point_heading,
  input  wire logic signed [COORD_WIDTH-1:0] in_car_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_car_y,
  input  wire logic signed [ANGLE_WIDTH-1:0] in_car_heading,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [ANGLE_WIDTH-1:0]      out_heading,
  output logic                               out_saturated
);

  localparam int CW = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int AW = ANGLE_WIDTH;
  localparam int NS = CORDIC_STAGES + 7;

  localparam int HD_LO = 0;
  localparam int OY_LO = HD_LO + AW;
  localparam int OX_LO = OY_LO + CW;
  localparam int B_LO  = OX_LO + CW;
  localparam int A_LO  = B_LO + DW;
  localparam int Q_LO  = A_LO + DW;
  localparam int F_LO  = Q_LO + 2;
  localparam int PW    = F_LO + 1;

  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // stage valids and load enables
  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  assign en[NS-1] = !vld_r[NS-1] || !out_stall;
  for (genvar g = 0; g < NS - 1; g++) begin : g_en
    assign en[g] = !vld_r[g] || en[g+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NS-1];

  // front stage: operands, heading result, quadrant and residual angle
  logic               rel;
  logic signed [DW-1:0] pxe, pye, cxe, cye;
  logic [31:0]        u, usum, r;
  logic [1:0]         q;

  logic                 f_r;
  logic [1:0]           q_r;
  logic signed [pft_pkg::Z_W-1:0] z_r;
  logic signed [DW-1:0] a_r, b_r;
  logic signed [CW-1:0] offx_r, offy_r;
  logic [AW-1:0]        hd_r;

  always_comb begin
    rel  = in_func == pft_pkg::FUNC_TO_REL;
    pxe  = DW'(in_point_x);
    pye  = DW'(in_point_y);
    cxe  = DW'(in_car_x);
    cye  = DW'(in_car_y);
    u    = {in_car_heading, {(32-AW){1'b0}}};
    usum = u + 32'h2000_0000;
    q    = usum[31:30];
    r    = u - {q, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f_r    <= in_func;
      q_r    <= q;
      z_r    <= pft_pkg::Z_W'($signed(r));
      a_r    <= rel ? pxe - cxe : pxe;
      b_r    <= rel ? pye - cye : pye;
      offx_r <= rel ? '0 : in_car_x;
      offy_r <= rel ? '0 : in_car_y;
      hd_r   <= rel ? AW'(in_point_heading - in_car_heading)
                    : AW'(in_point_heading + in_car_heading);
    end
  end

  // CORDIC cell chain
  logic signed [pft_pkg::XY_W-1:0] xs [CORDIC_STAGES+1];
  logic signed [pft_pkg::XY_W-1:0] ys [CORDIC_STAGES+1];
  logic signed [pft_pkg::Z_W-1:0]  zs [CORDIC_STAGES+1];
  logic        [PW-1:0]            ds [CORDIC_STAGES+1];

  assign xs[0] = pft_pkg::CORDIC_K;
  assign ys[0] = '0;
  assign zs[0] = z_r;
  assign ds[0] = {f_r, q_r, a_r, b_r, offx_r, offy_r, hd_r};

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    pft_cordic_cell #(
      .STAGE(k),
      .PW   (PW)
    ) u_cell (
      .clk(clk),
      .en (en[k+1]),
      .x_i(xs[k]),
      .y_i(ys[k]),
      .z_i(zs[k]),
      .d_i(ds[k]),
      .x_o(xs[k+1]),
      .y_o(ys[k+1]),
      .z_o(zs[k+1]),
      .d_o(ds[k+1])
    );
  end

  logic [PW-1:0] dn;
  assign dn = ds[CORDIC_STAGES];

  pft_rotator #(
    .COORD_WIDTH(COORD_WIDTH),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_rot (
    .clk          (clk),
    .en           (en[NS-1:NS-6]),
    .func_i       (dn[F_LO]),
    .q_i          (dn[Q_LO+1:Q_LO]),
    .x_i          (xs[CORDIC_STAGES]),
    .y_i          (ys[CORDIC_STAGES]),
    .a_i          ($signed(dn[A_LO+DW-1:A_LO])),
    .b_i          ($signed(dn[B_LO+DW-1:B_LO])),
    .offx_i       ($signed(dn[OX_LO+CW-1:OX_LO])),
    .offy_i       ($signed(dn[OY_LO+CW-1:OY_LO])),
    .hd_i         (dn[HD_LO+AW-1:HD_LO]),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_heading  (out_heading),
    .out_saturated(out_saturated)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r) && out_stall)
    else $error("input stalled with room in pipeline");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted word not captured");

  a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_x == SAT_MAX) || (out_x == SAT_MIN) || (out_y == SAT_MAX) || (out_y == SAT_MIN))
    else $error("saturation flag without clipped coordinate");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !vld_r[NS-2] |=> !out_valid)
    else $error("output word repeated");

endmodule
`default_nettype wire

FILE: sv/pft_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module pft_cordic_cell #(
  parameter int STAGE = 0,
  parameter int PW    = 1
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [pft_pkg::XY_W-1:0]   x_i,
  input  wire logic signed [pft_pkg::XY_W-1:0]   y_i,
  input  wire logic signed [pft_pkg::Z_W-1:0]    z_i,
  input  wire logic        [PW-1:0]              d_i,
  output logic signed      [pft_pkg::XY_W-1:0]   x_o,
  output logic signed      [pft_pkg::XY_W-1:0]   y_o,
  output logic signed      [pft_pkg::Z_W-1:0]    z_o,
  output logic             [PW-1:0]              d_o
);

  localparam logic signed [pft_pkg::Z_W-1:0] ANG =
    $signed({{(pft_pkg::Z_W-32){1'b0}}, pft_pkg::stage_angle(STAGE)});

  logic signed [pft_pkg::XY_W-1:0] dx, dy;
  logic signed [pft_pkg::XY_W-1:0] x_nxt, y_nxt, x_r, y_r;
  logic signed [pft_pkg::Z_W-1:0]  z_nxt, z_r;
  logic        [PW-1:0]            d_r;

  always_comb begin
    dx = y_i >>> STAGE;
    dy = x_i >>> STAGE;
    if (!z_i[pft_pkg::Z_W-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ANG;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
      d_r <= d_i;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
  assign d_o = d_r;

endmodule
`default_nettype wire

FILE: sv/pft_rotator.sv
`timescale 1ns / 1ps
`default_nettype none
module pft_rotator #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  wire logic                                clk,
  input  wire logic        [5:0]                   en,
  input  wire logic                                func_i,
  input  wire logic        [1:0]                   q_i,
  input  wire logic signed [pft_pkg::XY_W-1:0]     x_i,
  input  wire logic signed [pft_pkg::XY_W-1:0]     y_i,
  input  wire logic signed [COORD_WIDTH:0]         a_i,
  input  wire logic signed [COORD_WIDTH:0]         b_i,
  input  wire logic signed [COORD_WIDTH-1:0]       offx_i,
  input  wire logic signed [COORD_WIDTH-1:0]       offy_i,
  input  wire logic        [ANGLE_WIDTH-1:0]       hd_i,
  output logic signed      [COORD_WIDTH-1:0]       out_x,
  output logic signed      [COORD_WIDTH-1:0]       out_y,
  output logic signed      [ANGLE_WIDTH-1:0]       out_heading,
  output logic                                     out_saturated
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int XW  = pft_pkg::XY_W;
  localparam int L   = (DW + 1) / 2;
  localparam int HW  = DW - L;
  localparam int PHW = HW + XW;
  localparam int PLW = L + 1 + XW;
  localparam int PPW = DW + XW;
  localparam int SW  = PPW + 1;
  localparam int RW  = SW - 29;
  localparam logic signed [SW-1:0] RND = SW'(32'sd536870912);
  localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // quarter-turn fold
  logic signed [XW-1:0] c_nxt, s_nxt, c_r, s_r;
  logic signed [DW-1:0] a0_r, b0_r;
  logic                 f0_r;
  logic signed [CW-1:0] ox0_r, oy0_r;
  logic [ANGLE_WIDTH-1:0] hd0_r;

  always_comb begin
    case (pft_pkg::quad_t'(q_i))
      pft_pkg::QUAD_0:   begin c_nxt = x_i;  s_nxt = y_i;  end
      pft_pkg::QUAD_90:  begin c_nxt = -y_i; s_nxt = x_i;  end
      pft_pkg::QUAD_180: begin c_nxt = -x_i; s_nxt = -y_i; end
      default:           begin c_nxt = y_i;  s_nxt = -x_i; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c_r   <= c_nxt;
      s_r   <= s_nxt;
      a0_r  <= a_i;
      b0_r  <= b_i;
      f0_r  <= func_i;
      ox0_r <= offx_i;
      oy0_r <= offy_i;
      hd0_r <= hd_i;
    end
  end

  // partial products, operands split into signed high and unsigned low halves
  logic signed [HW-1:0] ah, bh;
  logic signed [L:0]    al, bl;
  logic signed [PHW-1:0] h_ac_r, h_bs_r, h_as_r, h_bc_r;
  logic signed [PLW-1:0] l_ac_r, l_bs_r, l_as_r, l_bc_r;
  logic                 f1_r;
  logic signed [CW-1:0] ox1_r, oy1_r;
  logic [ANGLE_WIDTH-1:0] hd1_r;

  assign ah = $signed(a0_r[DW-1:L]);
  assign bh = $signed(b0_r[DW-1:L]);
  assign al = $signed({1'b0, a0_r[L-1:0]});
  assign bl = $signed({1'b0, b0_r[L-1:0]});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      h_ac_r <= ah * c_r;
      h_bs_r <= bh * s_r;
      h_as_r <= ah * s_r;
      h_bc_r <= bh * c_r;
      l_ac_r <= al * c_r;
      l_bs_r <= bl * s_r;
      l_as_r <= al * s_r;
      l_bc_r <= bl * c_r;
      f1_r   <= f0_r;
      ox1_r  <= ox0_r;
      oy1_r  <= oy0_r;
      hd1_r  <= hd0_r;
    end
  end

  // full products
  logic signed [PPW-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  logic                 f2_r;
  logic signed [CW-1:0] ox2_r, oy2_r;
  logic [ANGLE_WIDTH-1:0] hd2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_ac_r <= $signed({h_ac_r, {L{1'b0}}}) + PPW'(l_ac_r);
      p_bs_r <= $signed({h_bs_r, {L{1'b0}}}) + PPW'(l_bs_r);
      p_as_r <= $signed({h_as_r, {L{1'b0}}}) + PPW'(l_as_r);
      p_bc_r <= $signed({h_bc_r, {L{1'b0}}}) + PPW'(l_bc_r);
      f2_r   <= f1_r;
      ox2_r  <= ox1_r;
      oy2_r  <= oy1_r;
      hd2_r  <= hd1_r;
    end
  end

  // rotated sums with half-up rounding bias
  logic signed [SW-1:0] sx_nxt, sy_nxt, sx_r, sy_r;
  logic signed [CW-1:0] ox3_r, oy3_r;
  logic [ANGLE_WIDTH-1:0] hd3_r;

  always_comb begin
    if (f2_r == pft_pkg::FUNC_TO_ABS) begin
      sx_nxt = SW'(p_ac_r) - SW'(p_bs_r) + RND;
      sy_nxt = SW'(p_as_r) + SW'(p_bc_r) + RND;
    end else begin
      sx_nxt = SW'(p_ac_r) + SW'(p_bs_r) + RND;
      sy_nxt = SW'(p_bc_r) - SW'(p_as_r) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      ox3_r <= ox2_r;
      oy3_r <= oy2_r;
      hd3_r <= hd2_r;
    end
  end

  // scale down and add vehicle offset
  logic signed [RW-1:0] rx_r, ry_r;
  logic [ANGLE_WIDTH-1:0] hd4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rx_r  <= RW'($signed(sx_r[SW-1:30])) + RW'(ox3_r);
      ry_r  <= RW'($signed(sy_r[SW-1:30])) + RW'(oy3_r);
      hd4_r <= hd3_r;
    end
  end

  // saturate
  logic                 ovx, ovy;
  logic signed [CW-1:0] vx, vy;
  logic signed [CW-1:0] ox_r, oy_r;
  logic [ANGLE_WIDTH-1:0] ohd_r;
  logic                 osat_r;

  always_comb begin
    ovx = rx_r[RW-1:CW-1] != {(RW-CW+1){rx_r[RW-1]}};
    ovy = ry_r[RW-1:CW-1] != {(RW-CW+1){ry_r[RW-1]}};
    vx  = ovx ? (rx_r[RW-1] ? SAT_MIN : SAT_MAX) : rx_r[CW-1:0];
    vy  = ovy ? (ry_r[RW-1] ? SAT_MIN : SAT_MAX) : ry_r[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      ox_r   <= vx;
      oy_r   <= vy;
      ohd_r  <= hd4_r;
      osat_r <= ovx | ovy;
    end
  end

  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_heading   = $signed(ohd_r);
  assign out_saturated = osat_r;

endmodule
`default_nettype wire

FILE: dv/planar_frame_transform_tb.sv
`timescale 1ns / 1ps
module planar_frame_transform_tb;

  localparam int STAGES  = 16;
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;
  localparam int LATENCY = STAGES + 7;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int LONG_HOLD = 200;

  localparam longint GAIN_SEED = 64'sd652032874;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam logic signed [COORD_W-1:0] ONE  = 32'sh0001_0000;
  localparam logic signed [COORD_W-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 32'sh8000_0000;

  // atan(2^-i), 32-bit binary angle
  localparam longint ATAN_TAB [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef enum int {
    PH_STEADY,
    PH_TX_GAPS,
    PH_RX_STALLS,
    PH_BOTH,
    PH_PRESSURE
  } phase_t;

  typedef struct packed {
    logic                      func;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [ANGLE_W-1:0] point_heading;
    logic signed [COORD_W-1:0] car_x;
    logic signed [COORD_W-1:0] car_y;
    logic signed [ANGLE_W-1:0] car_heading;
  } pose_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [ANGLE_W-1:0] heading;
    logic                      saturated;
  } pose_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      in_func = 1'b0;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [ANGLE_W-1:0] in_point_heading = '0;
  logic signed [COORD_W-1:0] in_car_x = '0;
  logic signed [COORD_W-1:0] in_car_y = '0;
  logic signed [ANGLE_W-1:0] in_car_heading = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [ANGLE_W-1:0] out_heading;
  logic                      out_saturated;

  pose_word_t   pending_words[$];
  pose_result_t expected_poses[$];
  pose_word_t   cur_word = '0;
  pose_word_t   drv_word;
  pose_result_t got_pose;
  pose_result_t want_pose;
  logic         in_acc = 1'b0;

  phase_t phase = PH_STEADY;
  int     tx_idle_pct = 0;
  int     rx_stall_pct = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  int     errors = 0;

  always #6 clk = ~clk;

  planar_frame_transform #(
    .CORDIC_STAGES(STAGES),
    .COORD_WIDTH  (COORD_W),
    .ANGLE_WIDTH  (ANGLE_W)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_point_x      (in_point_x),
    .in_point_y      (in_point_y),
    .in_point_heading(in_point_heading),
    .in_car_x        (in_car_x),
    .in_car_y        (in_car_y),
    .in_car_heading  (in_car_heading),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_heading     (out_heading),
    .out_saturated   (out_saturated)
  );

  // floor((a*ka + b*kb) / 2^30 + 1/2), exact
  function automatic longint rotate_round(longint a, longint b, longint ka, longint kb);
    logic signed [127:0] a_w, b_w, ka_w, kb_w, acc;
    logic [127:0] shifted;
    a_w = a;
    b_w = b;
    ka_w = ka;
    kb_w = kb;
    acc = a_w * ka_w + b_w * kb_w + (128'sd1 <<< 29);
    shifted = acc >>> 30;
    return shifted[63:0];
  endfunction

  function automatic logic [COORD_W:0] clip_coord(longint v);
    logic [63:0] bits;
    if (v > COORD_MAX) return {1'b1, CMAX};
    if (v < COORD_MIN) return {1'b1, CMIN};
    bits = v;
    return {1'b0, bits[COORD_W-1:0]};
  endfunction

  function automatic pose_result_t transform_pose(pose_word_t w);
    logic [31:0] u, uq, r;
    logic [1:0] q;
    longint x, y, z, dx, dy, c, s;
    longint px, py, cx, cy, rx, ry;
    logic [COORD_W:0] cx_clip, cy_clip;
    pose_result_t res;
    u = {w.car_heading, {(32-ANGLE_W){1'b0}}};
    uq = u + 32'h2000_0000;
    q = uq[31:30];
    r = u - {q, 30'd0};
    z = $signed(r);
    x = GAIN_SEED;
    y = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TAB[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TAB[i];
      end
    end
    case (pft_pkg::quad_t'(q))
      pft_pkg::QUAD_0: begin
        c = x;
        s = y;
      end
      pft_pkg::QUAD_90: begin
        c = -y;
        s = x;
      end
      pft_pkg::QUAD_180: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
    px = w.point_x;
    py = w.point_y;
    cx = w.car_x;
    cy = w.car_y;
    if (w.func == pft_pkg::FUNC_TO_ABS) begin
      rx = rotate_round(px, py, c, -s) + cx;
      ry = rotate_round(px, py, s, c) + cy;
      res.heading = w.point_heading + w.car_heading;
    end else begin
      rx = rotate_round(px - cx, py - cy, c, s);
      ry = rotate_round(px - cx, py - cy, -s, c);
      res.heading = w.point_heading - w.car_heading;
    end
    cx_clip = clip_coord(rx);
    cy_clip = clip_coord(ry);
    res.x = cx_clip[COORD_W-1:0];
    res.y = cy_clip[COORD_W-1:0];
    res.saturated = cx_clip[COORD_W] | cy_clip[COORD_W];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return CMAX;
      1: return CMIN;
      2, 3, 4: return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
      5: return $signed($urandom_range(0, 255)) - 32'sd128;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    logic [ANGLE_W-1:0] a;
    if ($urandom_range(0, 1) == 0) begin
      // near multiples of 45 degrees
      a = {3'($urandom_range(0, 7)), 13'd0};
      a = a + 16'($urandom_range(0, 4)) - 16'd2;
    end else begin
      a = 16'($urandom);
    end
    return a;
  endfunction

  task automatic add_word(logic f, logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                          logic signed [ANGLE_W-1:0] ph, logic signed [COORD_W-1:0] cx,
                          logic signed [COORD_W-1:0] cy, logic signed [ANGLE_W-1:0] ch);
    pose_word_t w;
    w.func = f;
    w.point_x = px;
    w.point_y = py;
    w.point_heading = ph;
    w.car_x = cx;
    w.car_y = cy;
    w.car_heading = ch;
    pending_words.push_back(w);
  endtask

  task automatic add_random_word();
    logic f;
    logic signed [COORD_W-1:0] px, py, cx, cy;
    f = 1'($urandom_range(0, 1));
    px = rand_coord();
    py = rand_coord();
    cx = rand_coord();
    cy = rand_coord();
    if (f == pft_pkg::FUNC_TO_REL && $urandom_range(0, 2) == 0) begin
      cx = px + $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      cy = py + $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
    end
    add_word(f, px, py, rand_angle(), cx, cy, rand_angle());
  endtask

  task automatic run_phase(phase_t p, int tx_pct, int rx_pct);
    phase = p;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (RANDOM_PER_PHASE) add_random_word();
    while (pending_words.size() != 0 || in_valid || expected_poses.size() != 0)
      @(posedge clk);
  endtask

  // input driver
  always @(negedge clk) begin
    if (!(in_valid && !in_acc)) begin
      if (pending_words.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        drv_word = pending_words.pop_front();
        cur_word = drv_word;
        in_func <= drv_word.func;
        in_point_x <= drv_word.point_x;
        in_point_y <= drv_word.point_y;
        in_point_heading <= drv_word.point_heading;
        in_car_x <= drv_word.car_x;
        in_car_y <= drv_word.car_y;
        in_car_heading <= drv_word.car_heading;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with one long hold-off in the pressure phase
  always @(negedge clk) begin
    if (phase == PH_PRESSURE && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_acc <= rst_n && in_valid && (in_stall === 1'b0);
    if (rst_n && in_valid && in_stall === 1'b0)
      expected_poses.push_back(transform_pose(cur_word));
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got_pose.x = out_x;
      got_pose.y = out_y;
      got_pose.heading = out_heading;
      got_pose.saturated = out_saturated;
      if (expected_poses.size() == 0) begin
        if (errors < 10)
          $display("unexpected word: x=%h y=%h h=%h sat=%b",
                   out_x, out_y, out_heading, out_saturated);
        errors = errors + 1;
      end else begin
        want_pose = expected_poses.pop_front();
        if (got_pose !== want_pose) begin
          if (errors < 10)
            $display("mismatch: exp x=%h y=%h h=%h sat=%b, got x=%h y=%h h=%h sat=%b",
                     want_pose.x, want_pose.y, want_pose.heading, want_pose.saturated,
                     got_pose.x, got_pose.y, got_pose.heading, got_pose.saturated);
          errors = errors + 1;
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_word(pft_pkg::FUNC_TO_ABS, 0, 0, 0, 0, 0, 0);
    add_word(pft_pkg::FUNC_TO_REL, 0, 0, 0, 0, 0, 0);
    add_word(pft_pkg::FUNC_TO_ABS, ONE, 2 * ONE, 16'sh1000, ONE, -ONE, 16'sh4000);
    add_word(pft_pkg::FUNC_TO_ABS, ONE, 2 * ONE, 0, 0, 0, 16'sh8000);
    add_word(pft_pkg::FUNC_TO_ABS, ONE, ONE, 0, 0, 0, 16'shC000);
    add_word(pft_pkg::FUNC_TO_ABS, ONE, 0, 0, 0, 0, 16'sh2000);
    add_word(pft_pkg::FUNC_TO_ABS, ONE, 0, 0, 0, 0, 16'sh1FFF);
    add_word(pft_pkg::FUNC_TO_REL, ONE, ONE, 0, 0, 0, 16'shE000);
    add_word(pft_pkg::FUNC_TO_REL, 3 * ONE, ONE, 0, ONE, ONE, 16'sh6000);
    add_word(pft_pkg::FUNC_TO_REL, 3 * ONE, -ONE, 16'sh0100, -ONE, ONE, 16'shA000);
    // heading wrap both ways
    add_word(pft_pkg::FUNC_TO_ABS, ONE, ONE, 16'sh7FFF, 0, 0, 16'sh0001);
    add_word(pft_pkg::FUNC_TO_REL, ONE, ONE, 16'sh8000, 0, 0, 16'sh0001);
    // saturation
    add_word(pft_pkg::FUNC_TO_ABS, CMAX, CMAX, 0, CMAX, CMAX, 0);
    add_word(pft_pkg::FUNC_TO_ABS, CMIN, CMIN, 0, CMIN, CMIN, 0);
    add_word(pft_pkg::FUNC_TO_REL, CMAX, CMIN, 0, CMIN, CMAX, 0);
    add_word(pft_pkg::FUNC_TO_REL, CMIN, CMAX, 0, CMAX, CMIN, 16'sh4000);
    add_word(pft_pkg::FUNC_TO_REL, CMAX, CMAX, 16'sh7FFF, CMAX, CMAX, 16'sh7FFF);
    add_word(pft_pkg::FUNC_TO_ABS, CMAX, CMAX, 16'sh7FFF, CMAX, CMAX, 16'sh7FFF);
    add_word(pft_pkg::FUNC_TO_ABS, CMIN, CMIN, 16'sh8000, CMIN, CMIN, 16'sh8000);
    add_word(pft_pkg::FUNC_TO_REL, CMIN, CMIN, 16'sh8000, CMIN, CMIN, 16'sh8000);
    // rounding at half an LSB
    add_word(pft_pkg::FUNC_TO_ABS, 32'sh0000_8000, -1, 0, 0, 0, 16'sh2AAA);
    add_word(pft_pkg::FUNC_TO_REL, 1, -1, 0, 0, 0, 16'sh5555);

    run_phase(PH_STEADY, 0, 0);
    run_phase(PH_TX_GAPS, 46, 0);
    run_phase(PH_RX_STALLS, 0, 46);
    run_phase(PH_BOTH, 28, 28);
    run_phase(PH_PRESSURE, 0, 0);

    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_poses.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: files.f
sv/pft_pkg.sv
sv/pft_cordic_cell.sv
sv/pft_rotator.sv
sv/planar_frame_transform.sv
dv/planar_frame_transform_tb.sv
